[rtl/wlpc_pkg.sv]
package wlpc_pkg;

    localparam int FIELD_W  = 11;
    localparam int WIDTH_W  = 31;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    // Union by rank keeps every rank at or below log2 of the node count.
    localparam int RANK_W   = 5;

    localparam logic [OP_W-1:0] OP_LOAD_TARGET = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_LINK   = 2'd1;
    localparam logic [OP_W-1:0] OP_START       = 2'd2;

    localparam logic [STATUS_W-1:0] ST_SOLVED      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_LINKS    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNREACHABLE = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SORT_I,
        S_SORT_KEY,
        S_SORT_CHK,
        S_SORT_CMP,
        S_CLR,
        S_CHK_INIT,
        S_CK_N,
        S_CK_T,
        S_FA,
        S_FB,
        S_M_K,
        S_M_L,
        S_MA,
        S_MB,
        S_BUMP,
        S_FIN_J,
        S_FIN_U
    } t_state;

    typedef enum logic [4:0] {
        C_NOP,
        C_LOAD_TGT,
        C_LOAD_LINK,
        C_START,
        C_RD_I,
        C_KEY,
        C_PLACE,
        C_RD_JM1,
        C_SHIFT,
        C_CLR,
        C_CHK_START,
        C_RD_TGT,
        C_FIND_NODE,
        C_STEP,
        C_FIND_TGT,
        C_NEXT_N,
        C_RD_LINK,
        C_FIND_FROM,
        C_FIND_TO,
        C_UNION,
        C_BUMP,
        C_EMIT_J,
        C_EMIT_U
    } t_cmd;

    typedef struct packed {
        logic i_done;
        logic j_zero;
        logic lt;
        logic clr_last;
        logic ck_done;
        logic found;
        logic same_root;
        logic rank_eq;
        logic links_done;
        logic out_busy;
    } t_sts;

endpackage

[rtl/wlpc_intf.sv]
interface wlpc_req_if;
    logic                               valid;
    logic                               ready;
    logic [wlpc_pkg::OP_W-1:0]          operation;
    logic [wlpc_pkg::FIELD_W-1:0]       node_index;
    logic [wlpc_pkg::FIELD_W-1:0]       node_target;
    logic [wlpc_pkg::FIELD_W-1:0]       link_from;
    logic [wlpc_pkg::FIELD_W-1:0]       link_to;
    logic [wlpc_pkg::WIDTH_W-1:0]       link_width;

    modport source (output valid, operation, node_index, node_target, link_from, link_to,
                    link_width, input ready);
    modport sink (input valid, operation, node_index, node_target, link_from, link_to,
                  link_width, output ready);
endinterface

interface wlpc_res_if;
    logic                               valid;
    logic                               ready;
    logic [wlpc_pkg::WIDTH_W-1:0]       bottleneck_width;
    logic [wlpc_pkg::STATUS_W-1:0]      status;

    modport source (output valid, bottleneck_width, status, input ready);
    modport sink (input valid, bottleneck_width, status, output ready);
endinterface

interface wlpc_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [wlpc_pkg::FIELD_W-1:0]       data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

[rtl/widest_link_permutation_connect.sv]
// Widest-link connection solver.
// i_req carries requests: load a node target, load a link, or start solving.
// Load requests are taken one per cycle and produce no result. A start sorts
// the links by decreasing width, resets the union-find forest and merges links
// in order until every node 1..node_count (capped at MAX_NODES) shares a root
// with its target, then sends one result on o_res: the width of the last link
// needed (status 0), status 1 when no link is needed, or status 2 when the
// links run out. A start runs an insertion sort on the link memory, clears the
// forest entries 0..MAX_NODES, and then runs a check before the first merge and
// after each merged link that walks the nodes in order up to the first one not
// joined, each node needing its two root searches. Requests are not taken while
// a solve runs. i_cfg writes node_count whenever it is valid; it is meant to be
// written while the block is idle, which the block itself does not enforce.
// Reset clears the link count and sets node_count to one; the target and link
// memories hold no defined content until written. A result waiting on a
// stalled receiver does not block loads; a finished solve holds until the
// result register is free.
module widest_link_permutation_connect #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_LINKS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wlpc_req_if.sink    i_req,
    wlpc_res_if.source  o_res,
    wlpc_cfg_if.sink    i_cfg
);

    wlpc_pkg::t_cmd cmd;
    wlpc_pkg::t_sts sts;

    assign i_cfg.ready = 1'b1;

    wlpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_op    (i_req.operation),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    wlpc_dp #(.MAX_NODES(MAX_NODES), .MAX_LINKS(MAX_LINKS)) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_node_index       (i_req.node_index),
        .i_node_target      (i_req.node_target),
        .i_link_from        (i_req.link_from),
        .i_link_to          (i_req.link_to),
        .i_link_width       (i_req.link_width),
        .i_cfg_valid        (i_cfg.valid),
        .i_cfg_data         (i_cfg.data),
        .o_res_valid        (o_res.valid),
        .i_res_ready        (o_res.ready),
        .o_bottleneck_width (o_res.bottleneck_width),
        .o_status           (o_res.status)
    );

endmodule

[rtl/wlpc_ram.sv]
module wlpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/wlpc_ctrl.sv]
module wlpc_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    input  logic [wlpc_pkg::OP_W-1:0]  i_req_op,
    output logic                       o_req_ready,
    input  wlpc_pkg::t_sts             i_sts,
    output wlpc_pkg::t_cmd             o_cmd
);

    wlpc_pkg::t_state r_state;
    wlpc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wlpc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = wlpc_pkg::C_NOP;
        o_req_ready = 1'b0;
        case (r_state)
            wlpc_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    case (i_req_op)
                        wlpc_pkg::OP_LOAD_TARGET: o_cmd = wlpc_pkg::C_LOAD_TGT;
                        wlpc_pkg::OP_LOAD_LINK:   o_cmd = wlpc_pkg::C_LOAD_LINK;
                        wlpc_pkg::OP_START: begin
                            o_cmd   = wlpc_pkg::C_START;
                            n_state = wlpc_pkg::S_SORT_I;
                        end
                        default: o_cmd = wlpc_pkg::C_NOP;
                    endcase
                end
            end
            // Insertion sort of the link list by decreasing width.
            wlpc_pkg::S_SORT_I: begin
                if (i_sts.i_done) begin
                    n_state = wlpc_pkg::S_CLR;
                end else begin
                    o_cmd   = wlpc_pkg::C_RD_I;
                    n_state = wlpc_pkg::S_SORT_KEY;
                end
            end
            wlpc_pkg::S_SORT_KEY: begin
                o_cmd   = wlpc_pkg::C_KEY;
                n_state = wlpc_pkg::S_SORT_CHK;
            end
            wlpc_pkg::S_SORT_CHK: begin
                if (i_sts.j_zero) begin
                    o_cmd   = wlpc_pkg::C_PLACE;
                    n_state = wlpc_pkg::S_SORT_I;
                end else begin
                    o_cmd   = wlpc_pkg::C_RD_JM1;
                    n_state = wlpc_pkg::S_SORT_CMP;
                end
            end
            wlpc_pkg::S_SORT_CMP: begin
                if (i_sts.lt) begin
                    o_cmd   = wlpc_pkg::C_SHIFT;
                    n_state = wlpc_pkg::S_SORT_CHK;
                end else begin
                    o_cmd   = wlpc_pkg::C_PLACE;
                    n_state = wlpc_pkg::S_SORT_I;
                end
            end
            wlpc_pkg::S_CLR: begin
                o_cmd = wlpc_pkg::C_CLR;
                if (i_sts.clr_last) begin
                    n_state = wlpc_pkg::S_CHK_INIT;
                end
            end
            wlpc_pkg::S_CHK_INIT: begin
                o_cmd   = wlpc_pkg::C_CHK_START;
                n_state = wlpc_pkg::S_CK_N;
            end
            wlpc_pkg::S_CK_N: begin
                if (i_sts.ck_done) begin
                    n_state = wlpc_pkg::S_FIN_J;
                end else begin
                    o_cmd   = wlpc_pkg::C_RD_TGT;
                    n_state = wlpc_pkg::S_CK_T;
                end
            end
            wlpc_pkg::S_CK_T: begin
                o_cmd   = wlpc_pkg::C_FIND_NODE;
                n_state = wlpc_pkg::S_FA;
            end
            wlpc_pkg::S_FA: begin
                if (i_sts.found) begin
                    o_cmd   = wlpc_pkg::C_FIND_TGT;
                    n_state = wlpc_pkg::S_FB;
                end else begin
                    o_cmd = wlpc_pkg::C_STEP;
                end
            end
            wlpc_pkg::S_FB: begin
                if (!i_sts.found) begin
                    o_cmd = wlpc_pkg::C_STEP;
                end else if (i_sts.same_root) begin
                    o_cmd   = wlpc_pkg::C_NEXT_N;
                    n_state = wlpc_pkg::S_CK_N;
                end else begin
                    n_state = wlpc_pkg::S_M_K;
                end
            end
            wlpc_pkg::S_M_K: begin
                if (i_sts.links_done) begin
                    n_state = wlpc_pkg::S_FIN_U;
                end else begin
                    o_cmd   = wlpc_pkg::C_RD_LINK;
                    n_state = wlpc_pkg::S_M_L;
                end
            end
            wlpc_pkg::S_M_L: begin
                o_cmd   = wlpc_pkg::C_FIND_FROM;
                n_state = wlpc_pkg::S_MA;
            end
            wlpc_pkg::S_MA: begin
                if (i_sts.found) begin
                    o_cmd   = wlpc_pkg::C_FIND_TO;
                    n_state = wlpc_pkg::S_MB;
                end else begin
                    o_cmd = wlpc_pkg::C_STEP;
                end
            end
            wlpc_pkg::S_MB: begin
                if (i_sts.found) begin
                    o_cmd   = wlpc_pkg::C_UNION;
                    n_state = i_sts.rank_eq ? wlpc_pkg::S_BUMP : wlpc_pkg::S_CHK_INIT;
                end else begin
                    o_cmd = wlpc_pkg::C_STEP;
                end
            end
            wlpc_pkg::S_BUMP: begin
                o_cmd   = wlpc_pkg::C_BUMP;
                n_state = wlpc_pkg::S_CHK_INIT;
            end
            wlpc_pkg::S_FIN_J: begin
                if (!i_sts.out_busy) begin
                    o_cmd   = wlpc_pkg::C_EMIT_J;
                    n_state = wlpc_pkg::S_IDLE;
                end
            end
            wlpc_pkg::S_FIN_U: begin
                if (!i_sts.out_busy) begin
                    o_cmd   = wlpc_pkg::C_EMIT_U;
                    n_state = wlpc_pkg::S_IDLE;
                end
            end
            default: n_state = wlpc_pkg::S_IDLE;
        endcase
    end

endmodule

[rtl/wlpc_dp.sv]
module wlpc_dp #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_LINKS = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  wlpc_pkg::t_cmd                  i_cmd,
    output wlpc_pkg::t_sts                  o_sts,
    input  logic [wlpc_pkg::FIELD_W-1:0]    i_node_index,
    input  logic [wlpc_pkg::FIELD_W-1:0]    i_node_target,
    input  logic [wlpc_pkg::FIELD_W-1:0]    i_link_from,
    input  logic [wlpc_pkg::FIELD_W-1:0]    i_link_to,
    input  logic [wlpc_pkg::WIDTH_W-1:0]    i_link_width,
    input  logic                            i_cfg_valid,
    input  logic [wlpc_pkg::FIELD_W-1:0]    i_cfg_data,
    output logic                            o_res_valid,
    input  logic                            i_res_ready,
    output logic [wlpc_pkg::WIDTH_W-1:0]    o_bottleneck_width,
    output logic [wlpc_pkg::STATUS_W-1:0]   o_status
);

    localparam int NODE_DEPTH = MAX_NODES + 1;
    localparam int NA = $clog2(NODE_DEPTH);
    localparam int NC = NA + 1;
    localparam int LA = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
    localparam int LC = $clog2(MAX_LINKS + 1);
    localparam int WW = wlpc_pkg::WIDTH_W;
    localparam int RK = wlpc_pkg::RANK_W;
    localparam int RW = 2 * NA + WW;
    localparam int UW = RK + NA;

    logic [wlpc_pkg::FIELD_W-1:0] r_node_count;
    logic [LC-1:0]                r_links;
    logic [LC-1:0]                r_i;
    logic [LC-1:0]                r_j;
    logic [LC-1:0]                r_k;
    logic [RW-1:0]                r_key;
    logic [RW-1:0]                r_rec;
    logic [NC-1:0]                r_n;
    logic [NA-1:0]                r_tgt;
    logic [NA-1:0]                r_cur;
    logic [NA-1:0]                r_ra;
    logic [RK-1:0]                r_rka;
    logic                         r_merged;
    logic [WW-1:0]                r_win;
    logic                         r_out_valid;
    logic [WW-1:0]                r_out_w;
    logic [wlpc_pkg::STATUS_W-1:0] r_out_st;

    logic          link_we;
    logic [LA-1:0] link_waddr;
    logic [RW-1:0] link_wdata;
    logic [LA-1:0] link_raddr;
    logic [RW-1:0] link_q;
    logic          uf_we;
    logic [NA-1:0] uf_waddr;
    logic [UW-1:0] uf_wdata;
    logic [NA-1:0] uf_raddr;
    logic [UW-1:0] uf_q;
    logic          tgt_we;
    logic [NA-1:0] tgt_q;
    logic [NA-1:0] w_parent;
    logic [RK-1:0] w_rank;
    logic [NC-1:0] w_nclamp;
    logic          w_tgt_ok;
    logic          w_link_ok;
    logic [LC-1:0] w_jm1;

    assign w_parent  = uf_q[NA-1:0];
    assign w_rank    = uf_q[UW-1:NA];
    assign w_nclamp  = (32'(r_node_count) > MAX_NODES) ? NC'(MAX_NODES) : NC'(r_node_count);
    assign w_tgt_ok  = (32'(i_node_index) <= MAX_NODES) && (32'(i_node_target) <= MAX_NODES);
    assign w_link_ok = (32'(i_link_from) <= MAX_NODES) && (32'(i_link_to) <= MAX_NODES)
                       && (32'(r_links) < MAX_LINKS);
    assign w_jm1     = r_j - LC'(1);

    always_comb begin
        o_sts.i_done     = r_i >= r_links;
        o_sts.j_zero     = r_j == '0;
        o_sts.lt         = link_q[WW-1:0] < r_key[WW-1:0];
        o_sts.clr_last   = 32'(r_n) == MAX_NODES;
        o_sts.ck_done    = r_n > w_nclamp;
        o_sts.found      = w_parent == r_cur;
        o_sts.same_root  = r_cur == r_ra;
        o_sts.rank_eq    = (w_rank == r_rka) && (r_cur != r_ra);
        o_sts.links_done = r_k >= r_links;
        o_sts.out_busy   = r_out_valid;
    end

    // Memory port steering.
    always_comb begin
        link_we    = 1'b0;
        link_waddr = r_j[LA-1:0];
        link_wdata = r_key;
        link_raddr = r_i[LA-1:0];
        uf_we      = 1'b0;
        uf_waddr   = r_n[NA-1:0];
        uf_wdata   = {RK'(0), r_n[NA-1:0]};
        uf_raddr   = w_parent;
        tgt_we     = 1'b0;
        case (i_cmd)
            wlpc_pkg::C_LOAD_TGT:  tgt_we = w_tgt_ok;
            wlpc_pkg::C_LOAD_LINK: begin
                link_we    = w_link_ok;
                link_waddr = r_links[LA-1:0];
                link_wdata = {NA'(i_link_from), NA'(i_link_to), i_link_width};
            end
            wlpc_pkg::C_RD_JM1:    link_raddr = w_jm1[LA-1:0];
            wlpc_pkg::C_SHIFT: begin
                link_we    = 1'b1;
                link_wdata = link_q;
            end
            wlpc_pkg::C_PLACE:     link_we = 1'b1;
            wlpc_pkg::C_RD_LINK:   link_raddr = r_k[LA-1:0];
            wlpc_pkg::C_CLR:       uf_we = 1'b1;
            wlpc_pkg::C_FIND_NODE: uf_raddr = r_n[NA-1:0];
            wlpc_pkg::C_FIND_TGT:  uf_raddr = r_tgt;
            wlpc_pkg::C_FIND_FROM: uf_raddr = link_q[RW-1 -: NA];
            wlpc_pkg::C_FIND_TO:   uf_raddr = r_rec[NA+WW-1 -: NA];
            wlpc_pkg::C_UNION: begin
                // The shallower tree hangs under the deeper one; ties hang the
                // second root under the first.
                uf_we = r_cur != r_ra;
                if (r_rka < w_rank) begin
                    uf_waddr = r_ra;
                    uf_wdata = {r_rka, r_cur};
                end else begin
                    uf_waddr = r_cur;
                    uf_wdata = {w_rank, r_ra};
                end
            end
            wlpc_pkg::C_BUMP: begin
                uf_we    = 1'b1;
                uf_waddr = r_ra;
                uf_wdata = {r_rka + RK'(1), r_ra};
            end
            default: link_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= wlpc_pkg::FIELD_W'(1);
            r_links      <= '0;
            r_out_valid  <= 1'b0;
            r_merged     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_node_count <= i_cfg_data;
            end
            if (r_out_valid && i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd)
                wlpc_pkg::C_LOAD_LINK: begin
                    if (w_link_ok) begin
                        r_links <= r_links + LC'(1);
                    end
                end
                wlpc_pkg::C_START:  r_merged <= 1'b0;
                wlpc_pkg::C_UNION:  r_merged <= 1'b1;
                wlpc_pkg::C_EMIT_J: r_out_valid <= 1'b1;
                wlpc_pkg::C_EMIT_U: r_out_valid <= 1'b1;
                default: r_merged <= r_merged;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            wlpc_pkg::C_START: begin
                r_i <= LC'(1);
                r_n <= '0;
                r_k <= '0;
            end
            wlpc_pkg::C_RD_I:       r_j <= r_i;
            wlpc_pkg::C_KEY:        r_key <= link_q;
            wlpc_pkg::C_SHIFT:      r_j <= w_jm1;
            wlpc_pkg::C_PLACE:      r_i <= r_i + LC'(1);
            wlpc_pkg::C_CLR:        r_n <= r_n + NC'(1);
            wlpc_pkg::C_CHK_START:  r_n <= NC'(1);
            wlpc_pkg::C_NEXT_N:     r_n <= r_n + NC'(1);
            wlpc_pkg::C_FIND_NODE: begin
                r_tgt <= tgt_q;
                r_cur <= r_n[NA-1:0];
            end
            wlpc_pkg::C_STEP:       r_cur <= w_parent;
            wlpc_pkg::C_FIND_TGT: begin
                r_ra  <= r_cur;
                r_rka <= w_rank;
                r_cur <= r_tgt;
            end
            wlpc_pkg::C_FIND_FROM: begin
                r_rec <= link_q;
                r_cur <= link_q[RW-1 -: NA];
            end
            wlpc_pkg::C_FIND_TO: begin
                r_ra  <= r_cur;
                r_rka <= w_rank;
                r_cur <= r_rec[NA+WW-1 -: NA];
            end
            wlpc_pkg::C_UNION: begin
                r_k   <= r_k + LC'(1);
                r_win <= r_rec[WW-1:0];
            end
            wlpc_pkg::C_EMIT_J: begin
                r_out_w  <= r_merged ? r_win : '0;
                r_out_st <= r_merged ? wlpc_pkg::ST_SOLVED : wlpc_pkg::ST_NO_LINKS;
            end
            wlpc_pkg::C_EMIT_U: begin
                r_out_w  <= '0;
                r_out_st <= wlpc_pkg::ST_UNREACHABLE;
            end
            default: r_cur <= r_cur;
        endcase
    end

    wlpc_ram #(.WIDTH(RW), .DEPTH(MAX_LINKS)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_q)
    );

    wlpc_ram #(.WIDTH(UW), .DEPTH(NODE_DEPTH)) u_uf_ram (
        .i_clk   (i_clk),
        .i_we    (uf_we),
        .i_waddr (uf_waddr),
        .i_wdata (uf_wdata),
        .i_raddr (uf_raddr),
        .o_rdata (uf_q)
    );

    wlpc_ram #(.WIDTH(NA), .DEPTH(NODE_DEPTH)) u_tgt_ram (
        .i_clk   (i_clk),
        .i_we    (tgt_we),
        .i_waddr (NA'(i_node_index)),
        .i_wdata (NA'(i_node_target)),
        .i_raddr (r_n[NA-1:0]),
        .o_rdata (tgt_q)
    );

    assign o_res_valid        = r_out_valid;
    assign o_bottleneck_width = r_out_w;
    assign o_status           = r_out_st;

    a_links_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_links) <= MAX_LINKS)
        else $error("link count passed the store depth");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == wlpc_pkg::C_EMIT_J || i_cmd == wlpc_pkg::C_EMIT_U) |-> !r_out_valid)
        else $error("result written over an unsent result");

    a_emit_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == wlpc_pkg::C_EMIT_J || i_cmd == wlpc_pkg::C_EMIT_U) |=> r_out_valid)
        else $error("result register not loaded");

    a_union_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == wlpc_pkg::C_BUMP) |-> $past(i_cmd == wlpc_pkg::C_UNION))
        else $error("rank raised without a merge");

endmodule

[bench/tb_top.sv]
module tb_top;

    typedef struct {
        logic [wlpc_pkg::OP_W-1:0]    op;
        logic [wlpc_pkg::FIELD_W-1:0] idx;
        logic [wlpc_pkg::FIELD_W-1:0] tgt;
        logic [wlpc_pkg::FIELD_W-1:0] lfrom;
        logic [wlpc_pkg::FIELD_W-1:0] lto;
        logic [wlpc_pkg::WIDTH_W-1:0] lwidth;
    } t_request;

    typedef struct {
        logic [wlpc_pkg::WIDTH_W-1:0]  width;
        logic [wlpc_pkg::STATUS_W-1:0] status;
    } t_answer;

    localparam int NODES = 1024;
    localparam int LINKS = 1024;
    localparam int CYCLE_LIMIT = 8000000;
    localparam int FW = wlpc_pkg::FIELD_W;
    localparam int WW = wlpc_pkg::WIDTH_W;
    // The one operation code that the block ignores.
    localparam logic [wlpc_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    logic clk;
    logic rst_n;

    wlpc_req_if req_if();
    wlpc_res_if res_if();
    wlpc_cfg_if cfg_if();

    widest_link_permutation_connect dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_if.sink),
        .o_res  (res_if.source),
        .i_cfg  (cfg_if.sink)
    );

    t_request request_q[$];
    t_answer  answer_q[$];

    int send_idle;
    int recv_stall;
    int error_count;
    int cycle_count;
    int hold_left;
    logic hold_go;

    // Shadow of the solver state.
    logic [FW-1:0] tgt_mem[0:NODES];
    logic [FW-1:0] forest[0:NODES];
    int            rank_of[0:NODES];
    logic [FW-1:0] link_a[0:LINKS-1];
    logic [FW-1:0] link_b[0:LINKS-1];
    logic [WW-1:0] link_w[0:LINKS-1];
    int            link_total;
    int            active_nodes;

    always #5 clk = ~clk;

    function automatic int find_root(int v);
        int r;
        int nxt;
        r = v;
        while (forest[r] != r)
            r = forest[r];
        while (forest[v] != r) begin
            nxt = forest[v];
            forest[v] = FW'(r);
            v = nxt;
        end
        return r;
    endfunction

    function automatic void join_pair(int a, int b);
        int ra;
        int rb;
        ra = find_root(a);
        rb = find_root(b);
        if (ra == rb)
            return;
        if (rank_of[ra] < rank_of[rb]) begin
            forest[ra] = FW'(rb);
        end else if (rank_of[ra] > rank_of[rb]) begin
            forest[rb] = FW'(ra);
        end else begin
            forest[rb] = FW'(ra);
            rank_of[ra]++;
        end
    endfunction

    function automatic bit every_node_joined();
        int n;
        n = (active_nodes > NODES) ? NODES : active_nodes;
        for (int i = 1; i <= n; i++)
            if (find_root(i) != find_root(tgt_mem[i]))
                return 0;
        return 1;
    endfunction

    function automatic void solve_widest();
        t_answer ans;
        logic [FW-1:0] fa;
        logic [FW-1:0] fb;
        logic [WW-1:0] wk;
        int j;
        // Stable insertion sort, widest first, kept in the store.
        for (int i = 1; i < link_total; i++) begin
            fa = link_a[i];
            fb = link_b[i];
            wk = link_w[i];
            j = i;
            while (j > 0 && link_w[j-1] < wk) begin
                link_a[j] = link_a[j-1];
                link_b[j] = link_b[j-1];
                link_w[j] = link_w[j-1];
                j--;
            end
            link_a[j] = fa;
            link_b[j] = fb;
            link_w[j] = wk;
        end
        for (int k = 0; k <= NODES; k++) begin
            forest[k] = FW'(k);
            rank_of[k] = 0;
        end
        ans.width = '0;
        ans.status = wlpc_pkg::ST_UNREACHABLE;
        if (every_node_joined()) begin
            ans.status = wlpc_pkg::ST_NO_LINKS;
        end else begin
            for (int k = 0; k < link_total; k++) begin
                join_pair(link_a[k], link_b[k]);
                if (every_node_joined()) begin
                    ans.width = link_w[k];
                    ans.status = wlpc_pkg::ST_SOLVED;
                    break;
                end
            end
        end
        answer_q.push_back(ans);
    endfunction

    function automatic void apply_request(t_request r);
        if (r.op == wlpc_pkg::OP_LOAD_TARGET) begin
            if (r.idx <= NODES && r.tgt <= NODES)
                tgt_mem[r.idx] = r.tgt;
        end else if (r.op == wlpc_pkg::OP_LOAD_LINK) begin
            if (r.lfrom <= NODES && r.lto <= NODES && link_total < LINKS) begin
                link_a[link_total] = r.lfrom;
                link_b[link_total] = r.lto;
                link_w[link_total] = r.lwidth;
                link_total++;
            end
        end else if (r.op == wlpc_pkg::OP_START) begin
            solve_widest();
        end
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // Request driver.
    always @(posedge clk) begin
        if (!rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_if.ready) begin
            if (request_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                t_request r;
                r = request_q.pop_front();
                req_if.valid       <= 1'b1;
                req_if.operation   <= r.op;
                req_if.node_index  <= r.idx;
                req_if.node_target <= r.tgt;
                req_if.link_from   <= r.lfrom;
                req_if.link_to     <= r.lto;
                req_if.link_width  <= r.lwidth;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (hold_go)
            hold_left <= 3000;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk) begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
            res_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall);
    end

    // Monitor: predict on accepted requests, check accepted results.
    always @(posedge clk) begin
        if (rst_n) begin
            if (req_if.valid && req_if.ready) begin
                t_request r;
                r.op = req_if.operation;
                r.idx = req_if.node_index;
                r.tgt = req_if.node_target;
                r.lfrom = req_if.link_from;
                r.lto = req_if.link_to;
                r.lwidth = req_if.link_width;
                apply_request(r);
            end
            if (res_if.valid && res_if.ready) begin
                if (answer_q.size() == 0) begin
                    report_mismatch("unexpected result, status", res_if.status, -1);
                end else begin
                    t_answer a;
                    a = answer_q.pop_front();
                    if (res_if.status !== a.status)
                        report_mismatch("status", res_if.status, a.status);
                    if (res_if.bottleneck_width !== a.width)
                        report_mismatch("bottleneck_width", res_if.bottleneck_width, a.width);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic push_target(int idx, int tgt);
        t_request r;
        r = '{wlpc_pkg::OP_LOAD_TARGET, FW'(idx), FW'(tgt), '0, '0, '0};
        request_q.push_back(r);
    endtask

    task automatic push_link(int a, int b, logic [WW-1:0] w);
        t_request r;
        r = '{wlpc_pkg::OP_LOAD_LINK, '0, '0, FW'(a), FW'(b), w};
        request_q.push_back(r);
    endtask

    task automatic push_start();
        t_request r;
        r = '{wlpc_pkg::OP_START, '0, '0, '0, '0, '0};
        request_q.push_back(r);
    endtask

    task automatic push_noise();
        t_request r;
        r.op = wlpc_pkg::OP_W'($urandom_range(3));
        if (r.op == wlpc_pkg::OP_START)
            r.op = OP_UNUSED;
        r.idx = FW'($urandom);
        r.tgt = FW'($urandom);
        r.lfrom = FW'($urandom);
        r.lto = FW'($urandom);
        r.lwidth = WW'($urandom);
        request_q.push_back(r);
    endtask

    task automatic wait_idle();
        while (request_q.size() > 0 || req_if.valid || answer_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_count(int value);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= FW'(value);
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        active_nodes = value;
    endtask

    task automatic random_set(int n);
        int nlinks;
        for (int i = 1; i <= n; i++)
            if ($urandom_range(3) != 0)
                push_target(i, $urandom_range(n + 1));
        nlinks = $urandom_range(5);
        for (int i = 0; i < nlinks; i++) begin
            logic [WW-1:0] w;
            case ($urandom_range(3))
                0: w = WW'($urandom_range(2));
                1: w = {WW{1'b1}};
                default: w = WW'($urandom);
            endcase
            push_link($urandom_range(n + 1), $urandom_range(n + 1), w);
        end
        repeat ($urandom_range(3)) push_noise();
        push_start();
    endtask

    initial begin
        int fill;
        clk = 1'b0;
        rst_n = 1'b0;
        hold_go = 1'b0;
        hold_left = 0;
        send_idle = 0;
        recv_stall = 0;
        error_count = 0;
        cycle_count = 0;
        link_total = 0;
        active_nodes = 1;
        req_if.valid = 1'b0;
        req_if.operation = '0;
        req_if.node_index = '0;
        req_if.node_target = '0;
        req_if.link_from = '0;
        req_if.link_to = '0;
        req_if.link_width = '0;
        res_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        for (int k = 0; k <= NODES; k++) begin
            tgt_mem[k] = FW'(k);
            forest[k] = FW'(k);
            rank_of[k] = 0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Every target gets a defined value before any start reads it.
        for (int i = 0; i <= NODES; i++)
            push_target(i, i);
        wait_idle();

        // Directed: no node checked, then no links at all.
        write_count(0);
        push_start();
        wait_idle();
        write_count(3);
        push_target(1, 2);
        push_target(2, 1);
        push_target(3, 0);
        push_start();
        wait_idle();
        push_link(1, 2, {WW{1'b1}});
        push_link(3, 0, '0);
        push_link(2, 3, WW'(5));
        push_link(NODES, NODES, WW'(5));
        push_link(NODES + 1, 1, WW'(9));
        push_link(1, 2047, WW'(9));
        push_target(2047, 1);
        push_target(1, NODES + 1);
        request_q.push_back('{OP_UNUSED, FW'(2047), FW'(2047), FW'(2047), FW'(2047),
                              {WW{1'b1}}});
        push_start();
        wait_idle();
        write_count(2047);
        push_start();
        wait_idle();
        write_count(NODES);
        push_target(NODES, 1);
        push_target(1, NODES);
        push_start();
        wait_idle();
        push_target(NODES, NODES);
        push_target(1, 1);

        // Random sets over the idling phases.
        for (int p = 0; p < 4; p++) begin
            wait_idle();
            case (p)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 82; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 82; end
                default: begin send_idle = 29; recv_stall = 29; end
            endcase
            for (int s = 0; s < 10; s++) begin
                int n;
                n = $urandom_range(2, 12);
                wait_idle();
                write_count(n);
                random_set(n);
            end
        end

        // The receiver holds off so that a finished solve backs up the requests.
        wait_idle();
        send_idle = 0;
        recv_stall = 0;
        write_count(4);
        @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
        random_set(4);
        random_set(4);
        for (int i = 0; i < 40; i++)
            push_target($urandom_range(1, 4), $urandom_range(5));
        push_start();

        // Fill the link list up, widths descending, and overflow it.
        wait_idle();
        write_count(2);
        push_target(1, 2);
        push_target(2, 1);
        wait_idle();
        fill = LINKS - link_total;
        for (int i = 0; i < fill; i++)
            push_link($urandom_range(3, 6), $urandom_range(3, 6), WW'(fill - i));
        push_link(1, 2, WW'(7));
        push_link(2, 1, WW'(8));
        push_start();

        wait_idle();
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
